### hw/rtl/gedp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GRE/ERSPAN decapsulation parser package
// Shared types and constants for the header parser and the descriptor
// builder.
// ----------------------------------------------------------------------------
package gedp_pkg;

   // IPv4 protocol number for GRE.
   localparam logic [7:0]  PROTO_GRE   = 8'd47;
   // GRE protocol types for ERSPAN type II and type III.
   localparam logic [15:0] TYPE_V1     = 16'h88be;
   localparam logic [15:0] TYPE_V2     = 16'h22eb;
   // ERSPAN header lengths in bytes.
   localparam logic [6:0]  HDR_V1      = 7'd8;
   localparam logic [6:0]  HDR_V2      = 7'd12;
   localparam logic [6:0]  SUBHDR_LEN  = 7'd8;
   // Byte of the ERSPAN header that carries the subheader bit.
   localparam logic [6:0]  SUBHDR_BYTE = 7'd11;
   // Width of header offsets: IP header plus GRE options and ERSPAN bytes.
   localparam int          OFF_W       = 7;
   localparam int          FIELD_W     = 15;

   // Descriptor status codes.
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOT_GRE = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_TRUNC   = 3'd4
   } status_type;

   // ERSPAN version codes.
   typedef enum logic [1:0] {
      VER_NONE = 2'd0,
      VER_1    = 2'd1,
      VER_2    = 2'd2
   } version_type;

   // Header fields gathered by the parser for one packet.
   typedef struct packed {
      logic        protocol_ok;
      logic [5:0]  ip_header_bytes;
      logic [2:0]  flag_bits;
      logic [15:0] encap_type;
      logic [15:0] gre_checksum;
      logic [31:0] gre_key;
      logic [31:0] gre_sequence;
      logic        subheader_seen;
   } summary_type;

   // One finished descriptor.
   typedef struct packed {
      status_type  status;
      logic [15:0] encap_type;
      logic [15:0] gre_checksum;
      logic [31:0] gre_key;
      logic [31:0] gre_sequence;
      logic [2:0]  present_mask;
      version_type erspan_version;
      logic [14:0] payload_offset;
      logic [14:0] payload_length;
   } descriptor_type;

endpackage
`default_nettype wire

### hw/rtl/gre_erspan_decap_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GRE/ERSPAN decapsulation parser
// Parses IPv4/GRE/ERSPAN type II and type III headers one byte per item and
// gives one descriptor per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle, starting at outer IPv4 header
// byte 0, with tlast on the final byte, and sustains one byte per cycle
// while the queue has room. The parser captures the header fields as bytes
// pass; the final byte puts a packet summary into a two-entry queue, and the
// descriptor builder turns it into a result, held in an output register
// until taken. A descriptor thus passes the queue and the output register
// before it is presented.
// Input stalls only when the queue is full, that is when two packet
// summaries wait behind an unread result. Bytes beyond MAX_LEN are
// ignored, and such a packet counts as MAX_LEN bytes long.
// ----------------------------------------------------------------------------
module gre_erspan_decap_parser #(
   parameter int MAX_LEN = 16384
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // data_byte
   input  wire logic         req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // encap_type[15:0], gre_checksum[31:16], gre_key[63:32], gre_sequence[95:64],
   // present_mask[98:96], erspan_version[100:99], payload_offset[115:101],
   // payload_length[130:116], zero fill[135:131]
   output logic [135:0]      rsp_tdata,
   output logic [2:0]        rsp_tuser    // status
);
   import gedp_pkg::*;

   localparam int POS_W   = $clog2(MAX_LEN + 1);
   localparam int ENTRY_W = POS_W + $bits(summary_type);

   logic                push, queue_full, pop, head_valid;
   summary_type         summary, head_summary;
   logic [POS_W-1:0]    byte_count, head_count;
   logic [ENTRY_W-1:0]  head_entry;
   descriptor_type      desc;

   // Byte parser.
   gedp_front #(
      .MAX_LEN (MAX_LEN),
      .POS_W   (POS_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .queue_full (queue_full),
      .push       (push),
      .summary    (summary),
      .byte_count (byte_count)
   );

   // Queue between parser and descriptor builder.
   gedp_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({byte_count, summary}),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_entry)
   );

   assign head_count   = head_entry[ENTRY_W-1 -: POS_W];
   assign head_summary = head_entry[$bits(summary_type)-1:0];

   // Descriptor builder.
   gedp_back #(
      .POS_W (POS_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_summary (head_summary),
      .head_count   (head_count),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_desc     (desc)
   );

   // Result packing.
   assign rsp_tuser = desc.status;
   assign rsp_tdata = {5'b00000,
                       desc.payload_length,
                       desc.payload_offset,
                       desc.erspan_version,
                       desc.present_mask,
                       desc.gre_sequence,
                       desc.gre_key,
                       desc.gre_checksum,
                       desc.encap_type};

endmodule
`default_nettype wire

### hw/rtl/gedp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GRE/ERSPAN header parser
// Counts byte positions of the incoming packet, captures the IP and GRE
// header fields and hands a summary of each packet to the queue on its
// final byte.
// ----------------------------------------------------------------------------
module gedp_front #(
   parameter int MAX_LEN = 16384,
   parameter int POS_W   = 15
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_last,
   output logic                      in_ready,
   input  wire logic                 queue_full,
   output logic                      push,
   output gedp_pkg::summary_type     summary,
   output logic [POS_W-1:0]          byte_count
);
   import gedp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   summary_type      hold_ff, hold_in;
   logic             accept;
   logic [OFF_W-1:0] ihl, co, ko, so, po;
   logic [POS_W-1:0] p;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign p        = pos_ff;

   // Header offsets; the header length from byte 0 applies at once.
   always_comb begin
      ihl = (pos_ff == '0) ? {1'b0, in_byte[3:0], 2'b00} : {1'b0, hold_ff.ip_header_bytes};
      co  = ihl + OFF_W'(4);
      ko  = co + (hold_ff.flag_bits[0] ? OFF_W'(4) : OFF_W'(0));
      so  = ko + (hold_ff.flag_bits[1] ? OFF_W'(4) : OFF_W'(0));
      po  = so + (hold_ff.flag_bits[2] ? OFF_W'(4) : OFF_W'(0));
   end

   // Field capture and packet summary.
   always_comb begin
      pos_in     = pos_ff;
      hold_in    = hold_ff;
      push       = 1'b0;
      summary    = hold_ff;
      byte_count = pos_ff;
      if (accept) begin
         if (pos_ff < POS_W'(MAX_LEN)) begin
            pos_in = pos_ff + POS_W'(1);
            if (p == '0) begin
               hold_in.ip_header_bytes = {in_byte[3:0], 2'b00};
            end
            if (p == POS_W'(9)) begin
               hold_in.protocol_ok = (in_byte == PROTO_GRE);
            end
            if (p == POS_W'(ihl)) begin
               hold_in.flag_bits = {in_byte[4], in_byte[5], in_byte[7]};
            end
            if (p == POS_W'(ihl + OFF_W'(2)) || p == POS_W'(ihl + OFF_W'(3))) begin
               hold_in.encap_type = {hold_ff.encap_type[7:0], in_byte};
            end
            // Fields behind the flag byte use the flags already held.
            if (p > POS_W'(ihl)) begin
               if (hold_ff.flag_bits[0] && p >= POS_W'(co) && p < POS_W'(co + OFF_W'(2))) begin
                  hold_in.gre_checksum = {hold_ff.gre_checksum[7:0], in_byte};
               end
               if (hold_ff.flag_bits[1] && p >= POS_W'(ko) && p < POS_W'(ko + OFF_W'(4))) begin
                  hold_in.gre_key = {hold_ff.gre_key[23:0], in_byte};
               end
               if (hold_ff.flag_bits[2] && p >= POS_W'(so) && p < POS_W'(so + OFF_W'(4))) begin
                  hold_in.gre_sequence = {hold_ff.gre_sequence[23:0], in_byte};
               end
               if (p == POS_W'(po + SUBHDR_BYTE)) begin
                  hold_in.subheader_seen = in_byte[0];
               end
            end
         end
         // The final byte sends the summary and starts a new packet.
         if (in_last) begin
            push       = 1'b1;
            summary    = hold_in;
            byte_count = pos_in;
            pos_in     = '0;
            hold_in    = '0;
         end
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hold_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         hold_ff <= hold_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/gedp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GRE/ERSPAN packet queue
// Two-entry queue that carries packet summaries from the parser to the
// descriptor builder, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module gedp_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/gedp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GRE/ERSPAN descriptor builder
// Turns a packet summary into a descriptor with status, GRE fields and the
// location of the inner frame, and holds it in the result register.
// ----------------------------------------------------------------------------
module gedp_back #(
   parameter int POS_W = 15
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  gedp_pkg::summary_type     head_summary,
   input  wire logic [POS_W-1:0]     head_count,
   output logic                      pop,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output gedp_pkg::descriptor_type  out_desc
);
   import gedp_pkg::*;

   localparam int CALC_W = (POS_W > FIELD_W) ? POS_W : FIELD_W;

   logic             valid_ff, valid_in;
   descriptor_type   desc_ff, desc_in;
   logic [OFF_W-1:0] po, hdr;
   logic [CALC_W-1:0] nr, plen, rest, off;
   logic              v1, v2;

   assign out_valid = valid_ff;
   assign out_desc  = desc_ff;
   assign pop       = head_valid && (!valid_ff || out_ready);

   // Descriptor from the queue head.
   always_comb begin
      po = OFF_W'(head_summary.ip_header_bytes) + OFF_W'(4)
         + (head_summary.flag_bits[0] ? OFF_W'(4) : OFF_W'(0))
         + (head_summary.flag_bits[1] ? OFF_W'(4) : OFF_W'(0))
         + (head_summary.flag_bits[2] ? OFF_W'(4) : OFF_W'(0));
      nr   = CALC_W'(head_count);
      plen = nr - CALC_W'(po);
      v1   = (head_summary.encap_type == TYPE_V1);
      v2   = (head_summary.encap_type == TYPE_V2);
      hdr  = v1 ? HDR_V1 : (HDR_V2 + (head_summary.subheader_seen ? SUBHDR_LEN : OFF_W'(0)));
      rest = plen - CALC_W'(hdr);
      off  = CALC_W'(po) + CALC_W'(hdr);

      desc_in.status         = ST_OK;
      desc_in.encap_type     = head_summary.encap_type;
      desc_in.gre_checksum   = head_summary.gre_checksum;
      desc_in.gre_key        = head_summary.gre_key;
      desc_in.gre_sequence   = head_summary.gre_sequence;
      desc_in.present_mask   = head_summary.flag_bits;
      desc_in.erspan_version = VER_NONE;
      desc_in.payload_offset = '0;
      desc_in.payload_length = '0;

      if (!head_summary.protocol_ok || nr < CALC_W'(po)) begin
         // Not GRE, or cut off inside the GRE header: report nothing else.
         desc_in        = '0;
         desc_in.status = ST_NOT_GRE;
      end else if (plen == '0) begin
         desc_in.status = ST_EMPTY;
      end else if (v1 || v2) begin
         desc_in.erspan_version = v1 ? VER_1 : VER_2;
         if (plen < CALC_W'(hdr)) begin
            desc_in.status = ST_TRUNC;
         end else begin
            desc_in.payload_offset = off[FIELD_W-1:0];
            desc_in.payload_length = rest[FIELD_W-1:0];
         end
      end else begin
         desc_in.status = ST_UNKNOWN;
      end
   end

   // Result register.
   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         desc_ff <= desc_in;
      end
   end

endmodule
`default_nettype wire
